// File: hw/rtl/cbae_pkg.sv
// Package for the cubic Bezier axis evaluator: widths, command codes and the
// Horner pipeline record shared by the top level and the step module.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cbae_pkg;

  // Fraction bits of the curve parameter: 1.0 = 2^PARAM_FRAC_BITS
  localparam int PARAM_FRAC_BITS = 16;

  // Field widths fixed by the interface
  localparam int CmdW   = 2;
  localparam int ParamW = 17;
  localparam int CoordW = 26;
  localparam int ValW   = 32;

  // Clamped parameter width (holds 1.0 exactly)
  localparam int TW = PARAM_FRAC_BITS + 1;
  // Width used for the clamp compare
  localparam int XW = (ParamW > TW) ? ParamW : TW;
  // Working width of the Horner sums: 6a needs about CoordW + 6 bits,
  // two bits of headroom on top
  localparam int SW = CoordW + 8;
  // Product width: signed sum times zero-extended parameter
  localparam int PW = SW + TW + 1;

  typedef enum logic [CmdW-1:0] {
    CmdPoint  = 2'd0,
    CmdFirst  = 2'd1,
    CmdSecond = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;

  // One item in flight through the Horner steps. addend[0] and en[0] belong
  // to the next step; each step shifts them down by one.
  typedef struct packed {
    logic signed [SW-1:0] s;
    logic [TW-1:0]        t;
    logic [2:0][SW-1:0]   addend;
    logic [2:0]           en;
  } horner_t;

endpackage

`default_nettype wire

// File: hw/rtl/cbae_horner_step.sv
// One Horner step, s <- round(s * t) + addend, as two register stages
// (multiply, then round and add). Depends on cbae_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbae_horner_step (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire cbae_pkg::horner_t pipe_i,
  output logic                  valid_o,
  output cbae_pkg::horner_t     pipe_o
);

  // stage A: product
  logic                             valid_a_q;
  cbae_pkg::horner_t                pipe_a_q;
  logic signed [cbae_pkg::PW-1:0]   prod_d, prod_q;

  // stage B: round, add, shift the pending terms down
  logic signed [cbae_pkg::PW-1:0]   w;
  logic signed [cbae_pkg::SW-1:0]   s_new;
  cbae_pkg::horner_t                pipe_b_d, pipe_b_q;
  logic                             valid_b_q;

  assign prod_d = cbae_pkg::PW'(pipe_i.s) *
                  cbae_pkg::PW'($signed({1'b0, pipe_i.t}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    pipe_a_q <= pipe_i;
    pipe_b_q <= pipe_b_d;
  end

  // round half up: floor((x + half) / 2^P) is an arithmetic shift
  assign w = prod_q +
             (cbae_pkg::PW'(1) <<< (cbae_pkg::PARAM_FRAC_BITS - 1));

  always_comb begin
    s_new = cbae_pkg::SW'(w >>> cbae_pkg::PARAM_FRAC_BITS) +
            $signed(pipe_a_q.addend[0]);
    pipe_b_d        = pipe_a_q;
    pipe_b_d.s      = pipe_a_q.en[0] ? s_new : pipe_a_q.s;
    pipe_b_d.addend = {cbae_pkg::SW'(0), pipe_a_q.addend[2:1]};
    pipe_b_d.en     = {1'b0, pipe_a_q.en[2:1]};
  end

  assign valid_o = valid_b_q;
  assign pipe_o  = pipe_b_q;

endmodule

`default_nettype wire

// File: hw/rtl/cubic_bezier_axis_evaluator.sv
// Top level of the cubic Bezier axis evaluator: input registers, coefficient
// set-up, three Horner steps and the saturating output register.
// Depends on cbae_pkg and cbae_horner_step.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// -----
// One transaction in: command, param_f and the two waypoints (position and
// tangent, signed Q17.8) are taken at a rising edge where start_i is high
// and busy_o is low. busy_o is tied low, so a transaction may be issued on
// every cycle; throughput is one transaction per clock.
// One transaction out per transaction in, in order: curve_value_o carries
// the point (command 0), first derivative (1) or second derivative (2),
// signed Q23.8 and saturated; command 3 gives zero. result_valid_o marks it
// for exactly one cycle.
// Path to the strobe: input register, coefficient register, three
// multiply/round-add step pairs, output register. Every item takes the same
// path; shorter commands just skip the Horner adds they do not need.
// param_f above 1.0 is clamped to 1.0.
// The receiver cannot stall; results are presented once and not held.
// Reset clears the valid bits of every stage, dropping any item in flight.

module cubic_bezier_axis_evaluator (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  output logic                                    busy_o,
  input  wire logic [cbae_pkg::CmdW-1:0]          command_i,
  input  wire logic [cbae_pkg::ParamW-1:0]        param_f_i,
  input  wire logic signed [cbae_pkg::CoordW-1:0] start_position_i,
  input  wire logic signed [cbae_pkg::CoordW-1:0] start_tangent_i,
  input  wire logic signed [cbae_pkg::CoordW-1:0] end_position_i,
  input  wire logic signed [cbae_pkg::CoordW-1:0] end_tangent_i,
  output logic                                    result_valid_o,
  output logic signed [cbae_pkg::ValW-1:0]        curve_value_o
);

  // ---------------------------------------------------------------------
  // Stage 1: capture the transaction, clamp the parameter
  // ---------------------------------------------------------------------
  logic                              accept;
  logic [cbae_pkg::XW-1:0]           f_x, one_x;
  logic [cbae_pkg::TW-1:0]           t_d;

  logic                              v1_q;
  cbae_pkg::cmd_e                    cmd1_q;
  logic [cbae_pkg::TW-1:0]           t1_q;
  logic signed [cbae_pkg::SW-1:0]    p0_q, st_q, p3_q, et_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign f_x   = cbae_pkg::XW'(param_f_i);
  assign one_x = cbae_pkg::XW'(1) << cbae_pkg::PARAM_FRAC_BITS;
  assign t_d   = (f_x > one_x) ? cbae_pkg::TW'(one_x) : cbae_pkg::TW'(f_x);

  always_ff @(posedge clk_i) begin
    cmd1_q <= cbae_pkg::cmd_e'(command_i);
    t1_q   <= t_d;
    p0_q   <= cbae_pkg::SW'(start_position_i);
    st_q   <= cbae_pkg::SW'(start_tangent_i);
    p3_q   <= cbae_pkg::SW'(end_position_i);
    et_q   <= cbae_pkg::SW'(end_tangent_i);
  end

  // ---------------------------------------------------------------------
  // Stage 2: power-form coefficients, scaled per command.
  //   a = 2*P0 + 3*ST - 2*P3 + 3*ET   (from -P0 + 3P1 - 3P2 + P3)
  //   b = -3*P0 - 6*ST + 3*P3 - 3*ET  (from 3P0 - 6P1 + 3P2)
  //   c = 3*ST, d = P0
  // point:  m = a,  adds b, c, d
  // first:  m = 3a, adds 2b, c
  // second: m = 6a, adds 2b
  // ---------------------------------------------------------------------
  logic signed [cbae_pkg::SW-1:0]    a_c, b_c, c_c;
  cbae_pkg::horner_t                 pipe2_d, pipe2_q;
  logic                              v2_q;

  assign a_c = (p0_q <<< 1) + (st_q <<< 1) + st_q - (p3_q <<< 1) + (et_q <<< 1) + et_q;
  assign b_c = (p3_q <<< 1) + p3_q - (p0_q <<< 1) - p0_q - (st_q <<< 2) - (st_q <<< 1)
             - (et_q <<< 1) - et_q;
  assign c_c = (st_q <<< 1) + st_q;

  always_comb begin
    pipe2_d.t      = t1_q;
    pipe2_d.s      = '0;
    pipe2_d.addend = '0;
    pipe2_d.en     = 3'b000;
    unique case (cmd1_q)
      cbae_pkg::CmdPoint: begin
        pipe2_d.s      = a_c;
        pipe2_d.addend = {p0_q, c_c, b_c};
        pipe2_d.en     = 3'b111;
      end
      cbae_pkg::CmdFirst: begin
        pipe2_d.s      = (a_c <<< 1) + a_c;
        pipe2_d.addend = {cbae_pkg::SW'(0), c_c, b_c <<< 1};
        pipe2_d.en     = 3'b011;
      end
      cbae_pkg::CmdSecond: begin
        pipe2_d.s      = (a_c <<< 2) + (a_c <<< 1);
        pipe2_d.addend = {cbae_pkg::SW'(0), cbae_pkg::SW'(0), b_c <<< 1};
        pipe2_d.en     = 3'b001;
      end
      default: begin
        // unused command: zero times t plus zero rounds to zero
        pipe2_d.s      = '0;
        pipe2_d.addend = '0;
        pipe2_d.en     = 3'b000;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    pipe2_q <= pipe2_d;
  end

  // ---------------------------------------------------------------------
  // Stages 3..8: three Horner steps, two stages each
  // ---------------------------------------------------------------------
  logic                              v_s1, v_s2, v_s3;
  cbae_pkg::horner_t                 pipe_s1, pipe_s2, pipe_s3;

  cbae_horner_step u_step1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .pipe_i  (pipe2_q),
    .valid_o (v_s1),
    .pipe_o  (pipe_s1)
  );

  cbae_horner_step u_step2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_s1),
    .pipe_i  (pipe_s1),
    .valid_o (v_s2),
    .pipe_o  (pipe_s2)
  );

  cbae_horner_step u_step3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_s2),
    .pipe_i  (pipe_s2),
    .valid_o (v_s3),
    .pipe_o  (pipe_s3)
  );

  // ---------------------------------------------------------------------
  // Stage 9: saturate to 32-bit signed and present for one cycle
  // ---------------------------------------------------------------------
  localparam logic signed [cbae_pkg::SW-1:0] SatMax =
    cbae_pkg::SW'({1'b0, {(cbae_pkg::ValW-1){1'b1}}});
  localparam logic signed [cbae_pkg::SW-1:0] SatMin = -SatMax - cbae_pkg::SW'(1);

  logic signed [cbae_pkg::ValW-1:0]  val_d, val_q;
  logic                              vout_q;

  always_comb begin
    if (pipe_s3.s > SatMax) begin
      val_d = cbae_pkg::ValW'(SatMax);
    end else if (pipe_s3.s < SatMin) begin
      val_d = cbae_pkg::ValW'(SatMin);
    end else begin
      val_d = cbae_pkg::ValW'(pipe_s3.s);
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      vout_q <= 1'b0;
    end else begin
      v1_q   <= accept;
      v2_q   <= v1_q;
      vout_q <= v_s3;
    end
  end

  assign result_valid_o = vout_q;
  assign curve_value_o  = val_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // every result strobe matches an earlier transaction on start_i
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i, 9))
    else $error("result strobe without matching transaction");

  // the unused command always yields zero
  a_unused_cmd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && $past(start_i, 9) &&
    ($past(command_i, 9) == cbae_pkg::CmdNone) |-> (curve_value_o == '0))
    else $error("unused command gave a non-zero value");

  // the last Horner step never has pending terms left over
  a_terms_consumed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_s3 |-> (pipe_s3.en == 3'b000))
    else $error("Horner terms left after the last step");

endmodule

`default_nettype wire

// File: tb/sv/cubic_bezier_axis_evaluator_test.sv
// Self-checking testbench for cubic_bezier_axis_evaluator: a queue-fed driver,
// a strobe monitor and a bit-exact predictor of the Horner evaluation.
// Depends on cbae_pkg and the evaluator RTL.
`timescale 1ns / 1ps

module cubic_bezier_axis_evaluator_test;
  import cbae_pkg::*;

  localparam longint FOne      = longint'(1) <<< PARAM_FRAC_BITS;
  localparam longint ParamMax  = (longint'(1) <<< ParamW) - 1;
  localparam longint CoordMax  = (longint'(1) <<< (CoordW - 1)) - 1;
  localparam longint CoordMin  = -(longint'(1) <<< (CoordW - 1));
  localparam longint ValMax    = (longint'(1) <<< (ValW - 1)) - 1;
  localparam longint ValMin    = -(longint'(1) <<< (ValW - 1));
  localparam int     RandomJobs = 1750;
  localparam int     DrainCycles = 16;  // pipeline is 9 deep, margin on top

  // One evaluation request plus the idle cycles the driver leaves after it
  typedef struct {
    cmd_e                     command;
    logic [ParamW-1:0]        param_f;
    logic signed [CoordW-1:0] start_position;
    logic signed [CoordW-1:0] start_tangent;
    logic signed [CoordW-1:0] end_position;
    logic signed [CoordW-1:0] end_tangent;
    int                       gap;
  } bezier_job_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic [CmdW-1:0]          command_i = '0;
  logic [ParamW-1:0]        param_f_i = '0;
  logic signed [CoordW-1:0] start_position_i = '0;
  logic signed [CoordW-1:0] start_tangent_i = '0;
  logic signed [CoordW-1:0] end_position_i = '0;
  logic signed [CoordW-1:0] end_tangent_i = '0;
  logic                     busy_o;
  logic                     result_valid_o;
  logic signed [ValW-1:0]   curve_value_o;

  bezier_job_t            pending_jobs[$];
  logic signed [ValW-1:0] expected_values[$];
  bezier_job_t            current_job;
  logic signed [ValW-1:0] want_value;
  int                     idle_left = 0;
  int                     no_idle_stretch = 0;
  int                     error_count = 0;
  int                     accepted_count = 0;
  int                     checked_count = 0;
  int                     clamped_count = 0;
  int                     cmd_seen[4] = '{0, 0, 0, 0};

  cubic_bezier_axis_evaluator uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .command_i        (command_i),
    .param_f_i        (param_f_i),
    .start_position_i (start_position_i),
    .start_tangent_i  (start_tangent_i),
    .end_position_i   (end_position_i),
    .end_tangent_i    (end_tangent_i),
    .result_valid_o   (result_valid_o),
    .curve_value_o    (curve_value_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Product by the parameter, rounded half up back to the coordinate format.
  // Arithmetic shift of a signed 64-bit value is a floor, as required.
  function automatic longint scale_by_f(input longint v, input longint f);
    return (v * f + (longint'(1) <<< (PARAM_FRAC_BITS - 1))) >>> PARAM_FRAC_BITS;
  endfunction

  // Point, slope or curvature of one axis, in power form by Horner's rule
  function automatic logic signed [ValW-1:0] bezier_axis_value(input bezier_job_t job);
    longint f, p0, p1, p2, p3, ca, cb, cc, acc;
    f  = longint'(job.param_f);
    if (f > FOne) f = FOne;  // parameter above one is clamped
    p0 = longint'(job.start_position);
    p1 = p0 + longint'(job.start_tangent);
    p3 = longint'(job.end_position);
    p2 = p3 - longint'(job.end_tangent);
    ca = -p0 + 3 * p1 - 3 * p2 + p3;
    cb = 3 * p0 - 6 * p1 + 3 * p2;
    cc = -3 * p0 + 3 * p1;
    case (job.command)
      CmdPoint: begin
        acc = scale_by_f(ca, f) + cb;
        acc = scale_by_f(acc, f) + cc;
        acc = scale_by_f(acc, f) + p0;
      end
      CmdFirst: begin
        acc = scale_by_f(3 * ca, f) + 2 * cb;
        acc = scale_by_f(acc, f) + cc;
      end
      CmdSecond: begin
        acc = scale_by_f(6 * ca, f) + 2 * cb;
      end
      default: begin
        acc = 0;  // unused command gives zero
      end
    endcase
    if (acc > ValMax) acc = ValMax;
    if (acc < ValMin) acc = ValMin;
    return acc[ValW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Idle cycles after a transaction: a uniform random gap, with runs of back-to-back issue
  function automatic int draw_gap();
    if (no_idle_stretch > 0) begin
      no_idle_stretch--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      no_idle_stretch = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  task automatic add_job(input cmd_e cmd, input longint f, input longint ps,
                         input longint ts, input longint pe, input longint te);
    bezier_job_t job;
    job.command        = cmd;
    job.param_f        = f[ParamW-1:0];
    job.start_position = ps[CoordW-1:0];
    job.start_tangent  = ts[CoordW-1:0];
    job.end_position   = pe[CoordW-1:0];
    job.end_tangent    = te[CoordW-1:0];
    job.gap            = draw_gap();
    pending_jobs.push_back(job);
  endtask

  // Mix of full-range values, extremes and small values near zero
  function automatic longint rand_coord();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: return CoordMax;
      1: return CoordMin;
      2, 3: return longint'($urandom_range(0, 4095)) - 2048;
      default: return longint'($signed(r[CoordW-1:0]));
    endcase
  endfunction

  function automatic longint rand_param();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return FOne;
      2: return longint'($urandom_range(FOne + 1, ParamMax));
      default: return longint'($urandom_range(0, FOne));
    endcase
  endfunction

  function automatic cmd_e rand_command();
    if ($urandom_range(0, 15) == 0) return CmdNone;
    return cmd_e'($urandom_range(0, 2));
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one transaction per launch, held until start_i meets !busy_o
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_values.push_back(bezier_axis_value(current_job));
        accepted_count++;
        cmd_seen[current_job.command]++;
        if (current_job.param_f > FOne) clamped_count++;
      end
      if (!start_i || !busy_o) begin
        if (idle_left > 0) begin
          idle_left--;
          start_i <= 1'b0;
        end else if (pending_jobs.size() > 0) begin
          current_job      = pending_jobs.pop_front();
          idle_left        = current_job.gap;
          command_i        <= current_job.command;
          param_f_i        <= current_job.param_f;
          start_position_i <= current_job.start_position;
          start_tangent_i  <= current_job.start_tangent;
          end_position_i   <= current_job.end_position;
          end_tangent_i    <= current_job.end_tangent;
          start_i          <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: the strobe cannot be stalled, so every pulse is one result
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_values.size() == 0) begin
        $error("result with nothing outstanding: curve_value %0d", curve_value_o);
        error_count++;
      end else begin
        want_value = expected_values.pop_front();
        checked_count++;
        if (curve_value_o !== want_value) begin
          $error("curve_value mismatch: expected %0d, actual %0d",
                 want_value, curve_value_o);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed corners, random traffic, drain and verdict
  // ---------------------------------------------------------------------------
  initial begin
    // Directed: every command at mid parameter
    add_job(CmdPoint,  32768, 1000, 256, -5000, 768);
    add_job(CmdFirst,  32768, 1000, 256, -5000, 768);
    add_job(CmdSecond, 32768, 1000, 256, -5000, 768);
    add_job(CmdNone,   32768, 1000, 256, -5000, 768);
    // Parameter at both ends of the segment
    add_job(CmdPoint,  0,    -777, 3001, 12345, -99);
    add_job(CmdFirst,  0,    -777, 3001, 12345, -99);
    add_job(CmdSecond, 0,    -777, 3001, 12345, -99);
    add_job(CmdPoint,  FOne, -777, 3001, 12345, -99);
    add_job(CmdFirst,  FOne, -777, 3001, 12345, -99);
    add_job(CmdSecond, FOne, -777, 3001, 12345, -99);
    // Parameter above one, clamped
    add_job(CmdPoint,  FOne + 1, 4321, -1234, 999, 55);
    add_job(CmdSecond, ParamMax, 4321, -1234, 999, 55);
    // Coordinate extremes, with all-equal and mixed signs
    add_job(CmdPoint,  21845,    CoordMax, CoordMax, CoordMax, CoordMax);
    add_job(CmdFirst,  43690,    CoordMax, CoordMax, CoordMax, CoordMax);
    add_job(CmdSecond, 1,        CoordMin, CoordMin, CoordMin, CoordMin);
    add_job(CmdFirst,  FOne - 1, CoordMin, CoordMin, CoordMin, CoordMin);
    add_job(CmdSecond, 0,        CoordMax, CoordMin, CoordMax, CoordMin);
    add_job(CmdSecond, FOne,     CoordMin, CoordMax, CoordMin, CoordMax);
    add_job(CmdPoint,  ParamMax, CoordMin, CoordMax, CoordMin, CoordMax);
    add_job(CmdFirst,  32768,    CoordMax, CoordMin, CoordMin, CoordMax);
    // A unit start position at half parameter, both signs
    add_job(CmdSecond, 32768, 1, 0, 0, 0);
    add_job(CmdSecond, 32768, -1, 0, 0, 0);

    for (int i = 0; i < RandomJobs; i++) begin
      add_job(rand_command(), rand_param(), rand_coord(), rand_coord(),
              rand_coord(), rand_coord());
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_jobs.size() != 0 || start_i) @(posedge clk_i);
    while (expected_values.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d transactions (point %0d, slope %0d, curvature %0d, unused %0d),",
             accepted_count, cmd_seen[CmdPoint], cmd_seen[CmdFirst],
             cmd_seen[CmdSecond], cmd_seen[CmdNone]);
    $display("%0d with a clamped parameter; %0d results compared.",
             clamped_count, checked_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: stops the run if it hangs
  initial begin
    #2000000;
    $display("Run did not finish in time");
    $display("TB_ERROR");
    $finish;
  end

endmodule
